@@ rtl/ucl_pkg.sv @@
package ucl_pkg;

  localparam int unsigned CmdWidth = 64;
  localparam int unsigned ArgWidth = 32;

  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [7:0] CharCr    = 8'h0D;
  localparam logic [7:0] CharLf    = 8'h0A;
  localparam logic [7:0] CharTab   = 8'h09;
  localparam logic [7:0] CharPlus  = 8'h2B;
  localparam logic [7:0] CharMinus = 8'h2D;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharLowX  = 8'h78;
  localparam logic [7:0] CharUpX   = 8'h58;

  localparam logic [ArgWidth-1:0] ArgPosMax = 32'h7FFF_FFFF;
  localparam logic [ArgWidth-1:0] ArgNegMax = 32'h8000_0000;

  localparam logic [CmdWidth-1:0] CmdZeroReset = 64'd500135195763;
  localparam logic [CmdWidth-1:0] CmdOneReset  = 64'd1886352499;

  typedef enum logic [2:0] {
    PhSpace   = 3'd0,
    PhSign    = 3'd1,
    PhZero    = 3'd2,
    PhPrefix  = 3'd3,
    PhDigits  = 3'd4,
    PhStopped = 3'd5,
    PhIdle    = 3'd6
  } phase_e;

  // one finished line as handed from the front part to the back part
  typedef struct packed {
    logic [CmdWidth-1:0] word;
    logic [3:0]          word_len;
    logic                has_args;
    logic [ArgWidth-1:0] arg_one;
    logic [ArgWidth-1:0] arg_two;
  } line_t;

  typedef struct packed {
    logic                status;
    logic                command_index;
    logic [ArgWidth-1:0] first_argument;
    logic [ArgWidth-1:0] second_argument;
  } result_t;

  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = 5'h10;
    if (c >= 8'h30 && c <= 8'h39) r = {1'b0, 4'(c - 8'h30)};
    else if (c >= 8'h41 && c <= 8'h46) r = {1'b0, 4'(c - 8'h41 + 8'd10)};
    else if (c >= 8'h61 && c <= 8'h66) r = {1'b0, 4'(c - 8'h61 + 8'd10)};
    return r;
  endfunction

  function automatic logic [3:0] word_length(input logic [CmdWidth-1:0] w);
    logic [3:0] n;
    n = '0;
    for (int i = 0; i < 8; i++) begin
      if (w[8*i +: 8] != 8'h00) n = 4'(i + 1);
    end
    return n;
  endfunction

endpackage

@@ rtl/ucl_stream_if.sv @@
interface ucl_stream_if #(
  parameter type payload_t = logic [7:0]
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ rtl/ucl_front.sv @@
module ucl_front #(
  parameter int unsigned LineLimit = 128
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [7:0]          in_byte_i,
  output logic                line_valid_o,
  input  logic                line_ready_i,
  output ucl_pkg::line_t      line_o
);
  import ucl_pkg::*;

  localparam int unsigned LenW = $clog2(LineLimit);

  logic [LenW-1:0]     len_q, len_d;
  logic [1:0]          tok_q, tok_d;
  logic                in_tok_q, in_tok_d;
  logic [CmdWidth-1:0] word_q, word_d;
  logic [3:0]          wlen_q, wlen_d;
  phase_e              ph_q, ph_d;
  logic                neg_q, neg_d;
  logic                sat_q, sat_d;
  logic [ArgWidth-1:0] a1_q, a1_d, a2_q, a2_d;
  logic                fire;
  logic                emit;
  line_t               line_d;

  assign in_ready_o = line_ready_i;
  assign fire       = in_valid_i && in_ready_o;

  // finalize the current magnitude into a signed value
  function automatic logic [ArgWidth-1:0] finalize(input logic [ArgWidth-1:0] m,
                                                  input logic n, input logic s);
    logic [ArgWidth-1:0] v;
    if (n) v = s ? ArgNegMax : (ArgWidth'(0) - m);
    else v = (s || m > ArgPosMax) ? ArgPosMax : m;
    return v;
  endfunction

  always_comb begin
    logic [7:0]          c;
    logic [4:0]          d;
    logic [ArgWidth-1:0] mag;
    logic [ArgWidth+3:0] t;
    logic                acc;
    logic                do_fin;
    phase_e              p;
    c = in_byte_i;
    d = hex_digit(c);
    len_d = len_q; tok_d = tok_q; in_tok_d = in_tok_q; word_d = word_q;
    wlen_d = wlen_q; ph_d = ph_q; neg_d = neg_q; sat_d = sat_q;
    a1_d = a1_q; a2_d = a2_q;
    emit = 1'b0;
    line_d = '0;
    acc = 1'b0;
    do_fin = 1'b0;
    p = ph_q;
    mag = '0;
    t = '0;

    if (fire) begin
      if (len_q >= LenW'(LineLimit - 1)) begin
        len_d = '0; tok_d = '0; in_tok_d = 1'b0; word_d = '0; wlen_d = '0;
        ph_d = PhSpace; neg_d = 1'b0; sat_d = 1'b0; a1_d = '0; a2_d = '0;
      end
      if (c == CharCr || c == CharLf) begin
        if (tok_d != 2'd0) begin
          emit = 1'b1;
          line_d.word     = word_d;
          line_d.word_len = wlen_d;
          line_d.has_args = tok_d > 2'd1;
          line_d.arg_one  = a1_d;
          line_d.arg_two  = a2_d;
          if (in_tok_d && tok_d >= 2'd2 && ph_d != PhIdle) begin
            if (tok_d == 2'd2) line_d.arg_one = finalize(a1_d, neg_d, sat_d);
            else line_d.arg_two = finalize(a2_d, neg_d, sat_d);
          end
        end
        len_d = '0; tok_d = '0; in_tok_d = 1'b0; word_d = '0; wlen_d = '0;
        ph_d = PhSpace; neg_d = 1'b0; sat_d = 1'b0; a1_d = '0; a2_d = '0;
      end else begin
        len_d = len_d + 1'b1;
        if (c == CharSpace) begin
          if (in_tok_d && tok_d >= 2'd2 && ph_d != PhIdle) do_fin = 1'b1;
          in_tok_d = 1'b0;
        end else begin
          if (!in_tok_d) begin
            in_tok_d = 1'b1;
            if (tok_d < 2'd3) begin
              tok_d = tok_d + 1'b1;
              if (tok_d >= 2'd2) begin
                ph_d = PhSpace; neg_d = 1'b0; sat_d = 1'b0;
                if (tok_d == 2'd2) a1_d = '0; else a2_d = '0;
              end
            end
          end
          if (tok_d == 2'd1) begin
            if (wlen_d < 4'd8) word_d[8*wlen_d[2:0] +: 8] = c;
            if (wlen_d < 4'd9) wlen_d = wlen_d + 1'b1;
          end else if (ph_d < PhStopped) begin
            p = ph_d;
            if (p == PhSpace) begin
              if (c == CharSpace || (c >= CharTab && c <= CharCr)) p = PhSpace;
              else if (c == CharPlus) ph_d = PhSign;
              else if (c == CharMinus) begin
                neg_d = 1'b1; ph_d = PhSign;
              end else p = PhSign;
            end
            if (p == PhSign) begin
              if (c == CharZero) ph_d = PhZero;
              else if (!d[4]) acc = 1'b1;
              else ph_d = PhStopped;
            end else if (p == PhZero) begin
              if (c == CharLowX || c == CharUpX) ph_d = PhPrefix;
              else if (!d[4]) acc = 1'b1;
              else ph_d = PhStopped;
            end else if (p == PhPrefix || p == PhDigits) begin
              if (!d[4]) acc = 1'b1;
              else ph_d = PhStopped;
            end
          end
        end
        mag = (tok_d == 2'd2) ? a1_d : a2_d;
        if (acc) begin
          ph_d = PhDigits;
          if (!sat_d) begin
            t = {mag, 4'h0} + (ArgWidth + 4)'(d[3:0]);
            if (t > (ArgWidth + 4)'(ArgNegMax)) sat_d = 1'b1;
            else mag = t[ArgWidth-1:0];
          end
        end
        if (do_fin) begin
          mag = finalize(mag, neg_d, sat_d);
          ph_d = PhIdle;
        end
        if (tok_d == 2'd2) a1_d = mag; else a2_d = mag;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= '0; tok_q <= '0; in_tok_q <= 1'b0; word_q <= '0; wlen_q <= '0;
      ph_q <= PhSpace; neg_q <= 1'b0; sat_q <= 1'b0; a1_q <= '0; a2_q <= '0;
      line_valid_o <= 1'b0;
    end else begin
      len_q <= len_d; tok_q <= tok_d; in_tok_q <= in_tok_d; word_q <= word_d;
      wlen_q <= wlen_d; ph_q <= ph_d; neg_q <= neg_d; sat_q <= sat_d;
      a1_q <= a1_d; a2_q <= a2_d;
      if (line_ready_i) line_valid_o <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit && line_ready_i) line_o <= line_d;
  end

endmodule

@@ rtl/ucl_queue.sv @@
module ucl_queue #(
  parameter int unsigned Depth = 2
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  output logic           space_o,
  input  ucl_pkg::line_t data_i,
  output logic           pop_valid_o,
  input  logic           pop_i,
  output ucl_pkg::line_t data_o
);
  import ucl_pkg::*;

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;

  line_t         mem [Depth];
  logic [AW-1:0] wp_q, rp_q;
  logic [AW:0]   cnt_q;
  logic          do_push, do_pop;

  assign do_push     = push_i && space_o;
  assign do_pop      = pop_i && pop_valid_o;
  assign pop_valid_o = cnt_q != '0;
  // space is offered while fewer than Depth lines are stored
  assign space_o     = cnt_q < (AW + 1)'(Depth);
  assign data_o      = mem[rp_q];

  always_ff @(posedge clk_i) begin
    if (do_push) mem[wp_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0; cnt_q <= '0;
    end else begin
      if (do_push) wp_q <= (wp_q == AW'(Depth - 1)) ? '0 : wp_q + 1'b1;
      if (do_pop) rp_q <= (rp_q == AW'(Depth - 1)) ? '0 : rp_q + 1'b1;
      cnt_q <= cnt_q + (AW + 1)'(do_push) - (AW + 1)'(do_pop);
    end
  end

endmodule

@@ rtl/ucl_back.sv @@
module ucl_back #(
  parameter int unsigned CommandCount = 2
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [$clog2(CommandCount+1)-1:0]      cfg_index_i,
  input  logic [ucl_pkg::CmdWidth-1:0]           cfg_data_i,
  input  logic                                   line_valid_i,
  output logic                                   line_pop_o,
  input  ucl_pkg::line_t                         line_i,
  output logic                                   res_valid_o,
  input  logic                                   res_ready_i,
  output ucl_pkg::result_t                       res_o
);
  import ucl_pkg::*;

  localparam int unsigned IW = $clog2(CommandCount + 1);
  localparam int unsigned CW = (CommandCount > 1) ? $clog2(CommandCount) : 1;

  logic [CmdWidth-1:0] cmd_q [CommandCount];
  logic [ArgWidth-1:0] k1_q, k2_q;
  logic                hit;
  logic [IW-1:0]       hit_idx;

  assign line_pop_o = line_valid_i && (!res_valid_o || res_ready_i);

  always_comb begin
    hit = 1'b0;
    hit_idx = '0;
    for (int i = CommandCount - 1; i >= 0; i--) begin
      if (line_i.word_len <= 4'd8 && word_length(cmd_q[i]) == line_i.word_len &&
          cmd_q[i] == line_i.word && cmd_q[i] != '0) begin
        hit = 1'b1;
        hit_idx = IW'(i);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CommandCount; i++) cmd_q[i] <= '0;
      cmd_q[0] <= CmdZeroReset;
      if (CommandCount > 1) cmd_q[CommandCount > 1 ? 1 : 0] <= CmdOneReset;
      k1_q <= '0; k2_q <= '0;
      res_valid_o <= 1'b0;
    end else begin
      if (cfg_we_i && cfg_index_i < IW'(CommandCount)) begin
        cmd_q[cfg_index_i[CW-1:0]] <= cfg_data_i;
      end
      if (line_pop_o) begin
        res_valid_o <= 1'b1;
        if (hit && line_i.has_args) begin
          k1_q <= line_i.arg_one; k2_q <= line_i.arg_two;
        end
      end else if (res_ready_i) begin
        res_valid_o <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (line_pop_o) begin
      if (!hit) begin
        res_o <= '{status: 1'b1, command_index: 1'b0, first_argument: '0,
                   second_argument: '0};
      end else begin
        res_o.status        <= 1'b0;
        res_o.command_index <= hit_idx[0];
        res_o.first_argument  <= line_i.has_args ? line_i.arg_one : k1_q;
        res_o.second_argument <= line_i.has_args ? line_i.arg_two : k2_q;
      end
    end
  end

endmodule

@@ rtl/uart_command_line_parser.sv @@
// channel | dir | payload                                   | transfer when
// rx      | in  | rx_byte[7:0]                              | valid & ready
// result  | out | status, command_index, first/second_arg   | valid & ready
// One byte per cycle enters the tokenizer while the queue has room; a line end
// gives a result via the front register, two-entry queue and matcher register.
// Reset clears all line state, kept arguments and restores both command words.
// The rx side stalls only when the line queue is full; bytes that are not a
// line end are never held back by a stalled result once the queue has room.
module uart_command_line_parser #(
  parameter int unsigned LINE_LIMIT    = 128,
  parameter int unsigned COMMAND_COUNT = 2
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [$clog2(COMMAND_COUNT+1)-1:0]    cfg_index_i,
  input  logic [63:0]                           cfg_data_i,
  ucl_stream_if.sink                            rx,
  ucl_stream_if.source                          res
);
  import ucl_pkg::*;

  logic  lv, lpop, qspace, qvalid;
  line_t lf, lq;
  result_t r;

  ucl_front #(.LineLimit(LINE_LIMIT)) u_front (
    .clk_i, .rst_ni,
    .in_valid_i(rx.valid), .in_ready_o(rx.ready), .in_byte_i(rx.data),
    .line_valid_o(lv), .line_ready_i(qspace), .line_o(lf)
  );

  ucl_queue #(.Depth(2)) u_queue (
    .clk_i, .rst_ni,
    .push_i(lv), .space_o(qspace), .data_i(lf),
    .pop_valid_o(qvalid), .pop_i(lpop), .data_o(lq)
  );

  ucl_back #(.CommandCount(COMMAND_COUNT)) u_back (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .line_valid_i(qvalid), .line_pop_o(lpop), .line_i(lq),
    .res_valid_o(res.valid), .res_ready_i(res.ready), .res_o(r)
  );

  assign res.data = r;

endmodule

@@ rtl/ucl_checker.sv @@
module ucl_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        rx_valid,
  input logic        res_valid,
  input logic        res_ready,
  input logic [65:0] res_data
);
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && !res_ready |=> res_valid && $stable(res_data)) else $error("result dropped");
  a_unknown_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && res_data[65] |-> res_data[64:0] == '0) else $error("unknown not zero");
  a_no_early: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !rx_valid ##1 !rx_valid |=> !$rose(res_valid) || $past(rx_valid, 3) || $past(res_valid))
    else $error("result without line");
endmodule

bind uart_command_line_parser ucl_checker u_checker (
  .clk_i, .rst_ni,
  .rx_valid(rx.valid),
  .res_valid(res.valid), .res_ready(res.ready), .res_data(res.data)
);

@@ verif/tb.sv @@
`timescale 1ns / 1ps

module tb;
  import ucl_pkg::*;

  localparam int unsigned LineLimit = 128;
  localparam int unsigned CmdCount  = 2;
  localparam int unsigned IdxWidth  = $clog2(CmdCount + 1);
  localparam logic [IdxWidth-1:0] RegCmdZero = IdxWidth'(0);
  localparam logic [IdxWidth-1:0] RegCmdOne  = IdxWidth'(1);
  localparam int unsigned IdleLimit = 5000;
  localparam int unsigned Drain     = 12;
  localparam int unsigned PhaseBytes = 150;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [IdxWidth-1:0] cfg_index_i = '0;
  logic [63:0] cfg_data_i = '0;

  ucl_stream_if #(.payload_t(logic [7:0])) rx_if ();
  ucl_stream_if #(.payload_t(result_t))    res_if ();

  uart_command_line_parser #(
    .LINE_LIMIT   (LineLimit),
    .COMMAND_COUNT(CmdCount)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .rx         (rx_if),
    .res        (res_if)
  );

  always #1 clk_i = ~clk_i;

  // ---------------- line predictor state ----------------
  logic [63:0] cmd_word [CmdCount];
  logic [6:0]  line_len;
  logic [1:0]  tok_cnt;
  logic        in_tok;
  logic [63:0] word_text;
  logic [3:0]  word_len;
  phase_e      ph;
  logic        neg, sat;
  logic [31:0] pend_one, pend_two, kept_one, kept_two;

  result_t     result_q [$];
  logic [7:0]  rx_q [$];

  int unsigned errors = 0;
  int unsigned bytes_sent = 0;
  int unsigned n_match = 0, n_unknown = 0;
  int unsigned hold_cycles = 0;
  bit          hold_req = 1'b0;
  int unsigned quiet = 0;

  task automatic clear_line();
    line_len = '0; tok_cnt = '0; in_tok = 1'b0; word_text = '0; word_len = '0;
    ph = PhSpace; neg = 1'b0; sat = 1'b0; pend_one = '0; pend_two = '0;
  endtask

  function automatic logic [3:0] name_len(input logic [63:0] w);
    logic [3:0] n;
    n = '0;
    for (int i = 0; i < 8; i++) if (w[8*i +: 8] != 8'h00) n = 4'(i + 1);
    return n;
  endfunction

  function automatic int digit_of(input logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c) - 48;
    if (c >= "A" && c <= "F") return int'(c) - 55;
    if (c >= "a" && c <= "f") return int'(c) - 87;
    return -1;
  endfunction

  function automatic logic [31:0] cur_mag();
    return (tok_cnt == 2'd2) ? pend_one : pend_two;
  endfunction

  task automatic set_mag(input logic [31:0] v);
    if (tok_cnt == 2'd2) pend_one = v;
    else pend_two = v;
  endtask

  task automatic add_digit(input int d);
    logic [35:0] t;
    if (!sat) begin
      t = ({4'b0, cur_mag()} << 4) + 36'(d);
      if (t > 36'h8000_0000) sat = 1'b1;
      else set_mag(t[31:0]);
    end
    ph = PhDigits;
  endtask

  task automatic close_arg();
    logic [31:0] m;
    m = cur_mag();
    if (neg) set_mag(sat ? ArgNegMax : -m);
    else set_mag((sat || m > ArgPosMax) ? ArgPosMax : m);
    ph = PhIdle;
  endtask

  task automatic parse_char(input logic [7:0] c);
    int d;
    phase_e p;
    d = digit_of(c);
    p = ph;
    if (p == PhSpace) begin
      if (c == CharSpace || (c >= CharTab && c <= CharCr)) return;
      if (c == CharPlus) begin ph = PhSign; return; end
      if (c == CharMinus) begin neg = 1'b1; ph = PhSign; return; end
      p = PhSign;
    end
    if (p == PhSign && c == CharZero) begin ph = PhZero; return; end
    if (p == PhZero && (c == CharLowX || c == CharUpX)) begin ph = PhPrefix; return; end
    if (d >= 0) add_digit(d);
    else ph = PhStopped;
  endtask

  task automatic predict_char(input logic [7:0] c);
    result_t r;
    int hit;
    if (line_len >= 7'(LineLimit - 1)) clear_line();
    if (c == CharCr || c == CharLf) begin
      if (tok_cnt == 0) begin clear_line(); return; end
      if (in_tok && tok_cnt >= 2 && ph != PhIdle) close_arg();
      hit = -1;
      if (word_len <= 8) begin
        for (int i = 0; i < CmdCount; i++) begin
          if (hit < 0 && name_len(cmd_word[i]) == word_len && cmd_word[i] == word_text)
            hit = i;
        end
      end
      if (hit < 0) begin
        r = '{status: 1'b1, command_index: 1'b0, first_argument: '0, second_argument: '0};
        n_unknown++;
      end else begin
        if (tok_cnt > 1) begin kept_one = pend_one; kept_two = pend_two; end
        r = '{status: 1'b0, command_index: 1'(hit), first_argument: kept_one,
              second_argument: kept_two};
        n_match++;
      end
      result_q.push_back(r);
      clear_line();
      return;
    end
    line_len++;
    if (c == CharSpace) begin
      if (in_tok && tok_cnt >= 2 && ph != PhIdle) close_arg();
      in_tok = 1'b0;
      return;
    end
    if (!in_tok) begin
      in_tok = 1'b1;
      if (tok_cnt < 3) begin
        tok_cnt++;
        if (tok_cnt >= 2) begin
          ph = PhSpace; neg = 1'b0; sat = 1'b0; set_mag('0);
        end
      end
    end
    if (tok_cnt == 1) begin
      if (word_len < 8) word_text |= 64'(c) << (8 * word_len);
      if (word_len < 9) word_len++;
    end else if (ph < PhStopped) begin
      parse_char(c);
    end
  endtask

  // ---------------- driver ----------------
  int unsigned gap = 0;
  bit          burst = 1'b0;

  initial begin
    rx_if.valid = 1'b0;
    rx_if.data = '0;
    res_if.ready = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && (!rx_if.valid || rx_if.ready)) begin
      if ($urandom_range(0, 199) == 0) burst <= ~burst;
      if (gap > 0) begin
        gap <= gap - 1;
        rx_if.valid <= 1'b0;
      end else if (rx_q.size() > 0) begin
        rx_if.valid <= 1'b1;
        rx_if.data <= rx_q.pop_front();
        if (burst || $urandom_range(0, 9) < 7) gap <= 0;
        else if ($urandom_range(0, 19) == 0) gap <= $urandom_range(10, 40);
        else gap <= $urandom_range(1, 3);
      end else begin
        rx_if.valid <= 1'b0;
      end
    end
  end

  // result side stalls, plus one long hold-off on request
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (hold_req && hold_cycles == 0) begin
        hold_cycles <= 400;
        res_if.ready <= 1'b0;
      end else if (hold_cycles > 1) begin
        hold_cycles <= hold_cycles - 1;
        res_if.ready <= 1'b0;
      end else begin
        if (hold_cycles == 1) hold_cycles <= 0;
        if (burst) res_if.ready <= 1'b1;
        else if ($urandom_range(0, 29) == 0) res_if.ready <= 1'b0;
        else res_if.ready <= ($urandom_range(0, 3) != 0);
      end
    end
  end

  // ---------------- monitor / checker ----------------
  always @(posedge clk_i) begin
    result_t e, a;
    bit moved;
    moved = 1'b0;
    if (rst_ni) begin
      if (rx_if.valid && rx_if.ready) begin
        predict_char(rx_if.data);
        bytes_sent++;
        moved = 1'b1;
      end
      if (res_if.valid && res_if.ready) begin
        moved = 1'b1;
        a = res_if.data;
        if (result_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result: %p", a);
        end else begin
          e = result_q.pop_front();
          if (a.status !== e.status || a.command_index !== e.command_index ||
              a.first_argument !== e.first_argument ||
              a.second_argument !== e.second_argument) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: exp %0d %0d %h %h got %0d %0d %h %h",
                       e.status, e.command_index, e.first_argument, e.second_argument,
                       a.status, a.command_index, a.first_argument, a.second_argument);
          end
        end
      end
      quiet <= moved ? 0 : quiet + 1;
      if (quiet >= IdleLimit) begin
        $display("watchdog: no transfer for %0d cycles", IdleLimit);
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // ---------------- stimulus ----------------
  task automatic push_str(input string s);
    for (int i = 0; i < s.len(); i++) rx_q.push_back(s[i]);
  endtask

  task automatic push_name(input logic [63:0] w);
    for (int i = 0; i < name_len(w); i++) rx_q.push_back(w[8*i +: 8]);
  endtask

  function automatic logic [7:0] hex_char();
    int d;
    d = $urandom_range(0, 15);
    if (d < 10) return 8'(48 + d);
    return ($urandom_range(0, 1) != 0) ? 8'(55 + d) : 8'(87 + d);
  endfunction

  task automatic push_arg();
    int n;
    if ($urandom_range(0, 7) == 0) rx_q.push_back(8'($urandom_range(9, 12)));
    case ($urandom_range(0, 3))
      0: rx_q.push_back(CharPlus);
      1: rx_q.push_back(CharMinus);
      default: ;
    endcase
    if ($urandom_range(0, 2) == 0) begin
      rx_q.push_back(CharZero);
      if ($urandom_range(0, 3) != 0) rx_q.push_back($urandom_range(0, 1) ? CharLowX : CharUpX);
    end
    n = ($urandom_range(0, 5) == 0) ? $urandom_range(8, 11) : $urandom_range(0, 8);
    for (int i = 0; i < n; i++) rx_q.push_back(hex_char());
    if ($urandom_range(0, 9) == 0) rx_q.push_back(8'($urandom_range(0, 255)));
  endtask

  task automatic push_line();
    int kind, nargs;
    if ($urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 2)) rx_q.push_back(CharSpace);
    kind = $urandom_range(0, 9);
    if (kind < 4) push_name(cmd_word[0]);
    else if (kind < 8) push_name(cmd_word[1]);
    else repeat ($urandom_range(1, 10)) rx_q.push_back(8'($urandom_range(33, 126)));
    nargs = $urandom_range(0, 4);
    for (int i = 0; i < nargs; i++) begin
      repeat ($urandom_range(1, 2)) rx_q.push_back(CharSpace);
      push_arg();
    end
    if ($urandom_range(0, 4) == 0) rx_q.push_back(CharSpace);
    rx_q.push_back($urandom_range(0, 1) ? CharCr : CharLf);
  endtask

  task automatic push_noise();
    repeat ($urandom_range(1, 12)) rx_q.push_back(8'($urandom_range(0, 255)));
  endtask

  task automatic wait_idle();
    wait (rx_q.size() == 0 && !rx_if.valid && result_q.size() == 0);
    repeat (Drain) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [IdxWidth-1:0] idx, input logic [63:0] v);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= v;
    cmd_word[idx] = v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic random_phase();
    int unsigned start;
    start = bytes_sent + rx_q.size();
    while (bytes_sent + rx_q.size() < start + PhaseBytes) begin
      if ($urandom_range(0, 9) == 0) push_noise();
      else push_line();
      wait (rx_q.size() < 64);
    end
    wait_idle();
  endtask

  initial begin
    logic [63:0] w;
    cmd_word[0] = CmdZeroReset;
    cmd_word[1] = CmdOneReset;
    clear_line();
    kept_one = '0;
    kept_two = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extremes, saturation, prefixes, blank lines, kept params, overflow
    push_str("start 7fffffff -80000000\r");
    push_str("stop\n");
    push_str("start 80000000 -80000001\r");
    push_str("stop +0x1A 0X\n");
    push_str("  \r\n");
    push_str("startx 1 2\r");
    push_str("start 12\n");
    repeat (140) rx_q.push_back(8'h00);
    push_str("stop 1 2 3 4\r");
    wait_idle();

    // input stall while result side holds off
    hold_req = 1'b1;
    repeat (40) push_line();
    wait (hold_cycles > 0);
    hold_req = 1'b0;
    wait_idle();

    random_phase();

    write_reg(RegCmdZero, "hgfedcba");
    write_reg(RegCmdOne, 64'h73);
    random_phase();

    write_reg(RegCmdZero, '1);
    write_reg(RegCmdOne, '0);
    random_phase();

    w = '0;
    for (int i = 0; i < $urandom_range(1, 8); i++) w[8*i +: 8] = 8'($urandom_range(1, 255));
    write_reg(RegCmdZero, w);
    write_reg(RegCmdOne, w);
    random_phase();

    write_reg(RegCmdZero, CmdZeroReset);
    write_reg(RegCmdOne, CmdOneReset);
    random_phase();

    $display("run covered %0d bytes: %0d matched commands, %0d unknown commands",
             bytes_sent, n_match, n_unknown);
    $display("five command-word settings, one long result hold-off, line overflow");
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/ucl_pkg.sv
rtl/ucl_stream_if.sv
rtl/ucl_front.sv
rtl/ucl_queue.sv
rtl/ucl_back.sv
rtl/uart_command_line_parser.sv
rtl/ucl_checker.sv
verif/tb.sv
